// ===== design/mfq_pkg.sv =====
`default_nettype none

package mfq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int LEVELS      = 4;
	localparam int ID_W        = 16;
	localparam int QUANTUM_W   = 25;
	localparam int LEVEL_W     = 2;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 48;

	localparam logic [LEVEL_W-1:0] LVL_REALTIME = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_HIGH     = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_MEDIUM   = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_LOW      = 2'd3;

	localparam logic OP_ADMIT    = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [QUANTUM_W-1:0] QUANTUM_REALTIME_RST = 25'd2000000;
	localparam logic [QUANTUM_W-1:0] QUANTUM_HIGH_RST     = 25'd4000000;
	localparam logic [QUANTUM_W-1:0] QUANTUM_MEDIUM_RST   = 25'd8000000;
	localparam logic [QUANTUM_W-1:0] QUANTUM_LOW_RST      = 25'd16000000;

	typedef struct packed {
		logic            opcode;
		logic [ID_W-1:0] task_id;
		logic            realtime_req;
		logic            finished;
	} mfq_item_t;

	typedef struct packed {
		logic                 ok;
		logic [ID_W-1:0]      chosen_id;
		logic [LEVEL_W-1:0]   chosen_level;
		logic [QUANTUM_W-1:0] slice;
		logic                 dropped;
	} mfq_result_t;

	// Request from the control logic to one queue.
	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] push_id;
	} mfq_qctl_t;

	// Status of one queue.
	typedef struct packed {
		logic            empty;
		logic            full;
		logic [ID_W-1:0] head;
	} mfq_qstat_t;

endpackage

`default_nettype wire

// ===== design/mfq_queue.sv =====
`default_nettype none

module mfq_queue #(
	parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mfq_pkg::mfq_qctl_t ctl,
	output mfq_pkg::mfq_qstat_t     stat
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [mfq_pkg::ID_W-1:0] entries_q [QUEUE_DEPTH];
	logic [CW-1:0]            count_q;
	logic                     full;
	logic                     empty;
	logic                     push_eff;
	logic                     pop_eff;
	logic [CW-1:0]            wr_pos;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_eff  = ctl.pop && !empty;
	// A push into a full queue fits only when the head leaves in the same cycle.
	assign push_eff = ctl.push && (!full || pop_eff);
	assign wr_pos   = pop_eff ? (count_q - CW'(1)) : count_q;

	assign stat.empty = empty;
	assign stat.full  = full;
	assign stat.head  = entries_q[0];

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (push_eff && (CW'(k) == wr_pos)) begin
				entries_q[k] <= ctl.push_id;
			end else if (pop_eff && (k < QUEUE_DEPTH - 1)) begin
				entries_q[k] <= entries_q[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push_eff && !pop_eff) begin
			count_q <= count_q + CW'(1);
		end else if (pop_eff && !push_eff) begin
			count_q <= count_q - CW'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !empty)
		else $error("pop requested from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push && !ctl.pop |-> !full)
		else $error("push requested into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push && !ctl.pop && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("fill count did not advance on push");

endmodule

`default_nettype wire

// ===== design/mfq_ctrl.sv =====
`default_nettype none

module mfq_ctrl (
	input  wire logic                                           fire,
	input  wire mfq_pkg::mfq_item_t                             item,
	input  wire mfq_pkg::mfq_qstat_t                            qstat [mfq_pkg::LEVELS],
	input  wire logic [mfq_pkg::LEVELS-1:0][mfq_pkg::QUANTUM_W-1:0] quantum,
	output mfq_pkg::mfq_qctl_t                                  qctl [mfq_pkg::LEVELS],
	output mfq_pkg::mfq_result_t                                result
);

	logic [mfq_pkg::LEVEL_W-1:0] lvl;
	logic [mfq_pkg::LEVEL_W-1:0] dest;
	logic [mfq_pkg::LEVEL_W-1:0] target;
	logic                        any_task;

	always_comb begin
		any_task = 1'b1;
		if (!qstat[0].empty) begin
			lvl = mfq_pkg::LVL_REALTIME;
		end else if (!qstat[1].empty) begin
			lvl = mfq_pkg::LVL_HIGH;
		end else if (!qstat[2].empty) begin
			lvl = mfq_pkg::LVL_MEDIUM;
		end else if (!qstat[3].empty) begin
			lvl = mfq_pkg::LVL_LOW;
		end else begin
			lvl      = mfq_pkg::LVL_REALTIME;
			any_task = 1'b0;
		end

		// The two middle levels demote; the top and bottom levels rotate in place.
		if (lvl == mfq_pkg::LVL_HIGH) begin
			dest = mfq_pkg::LVL_MEDIUM;
		end else if (lvl == mfq_pkg::LVL_MEDIUM) begin
			dest = mfq_pkg::LVL_LOW;
		end else begin
			dest = lvl;
		end

		target = item.realtime_req ? mfq_pkg::LVL_REALTIME : mfq_pkg::LVL_HIGH;

		for (int k = 0; k < mfq_pkg::LEVELS; k++) begin
			qctl[k].push    = 1'b0;
			qctl[k].pop     = 1'b0;
			qctl[k].push_id = item.task_id;
		end
		result = '0;

		if (item.opcode == mfq_pkg::OP_ADMIT) begin
			if (item.task_id != '0) begin
				if (!qstat[target].full) begin
					qctl[target].push = fire;
					result.ok         = 1'b1;
				end else begin
					result.dropped = 1'b1;
				end
			end
		end else if (any_task) begin
			qctl[lvl].pop       = fire;
			result.ok           = 1'b1;
			result.chosen_id    = qstat[lvl].head;
			result.chosen_level = lvl;
			result.slice        = quantum[lvl];
			if (!item.finished) begin
				qctl[dest].push_id = qstat[lvl].head;
				if (dest == lvl || !qstat[dest].full) begin
					qctl[dest].push = fire;
				end else begin
					result.dropped = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/multilevel_feedback_queue_scheduler.sv =====
// Pipeline: an accepted item is taken into the input register, and its result is taken into the
// result register when that register is empty or being read; m_tvalid comes from the result register.
// Throughput: one item per cycle through the four shift-register queues while the output is
// not stalled; a stalled output holds one result while one more item waits.
// Reset: asynchronous, active low; empties all queues, clears both valid flags and
// returns the four quanta to their default values.
`default_nettype none

module multilevel_feedback_queue_scheduler #(
	parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// task_id [15:0], realtime_req [16], finished [17], zero fill [23:18]
	input  wire logic [mfq_pkg::IN_DATA_W-1:0]   s_tdata,
	// opcode [0]
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// ok [0], chosen_id [16:1], chosen_level [18:17], slice [43:19], dropped [44],
	// zero fill [47:45]
	output logic [mfq_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [mfq_pkg::LEVEL_W-1:0]     cfg_index,
	input  wire logic [mfq_pkg::QUANTUM_W-1:0]   cfg_data
);

	logic [mfq_pkg::LEVELS-1:0][mfq_pkg::QUANTUM_W-1:0] quantum_q;

	mfq_pkg::mfq_item_t   item_s1;
	logic                 valid_s1;
	mfq_pkg::mfq_result_t result_q;
	mfq_pkg::mfq_result_t result_next;
	logic                 out_valid_q;
	logic                 fire;
	logic                 s_accept;

	mfq_pkg::mfq_qctl_t  qctl  [mfq_pkg::LEVELS];
	mfq_pkg::mfq_qstat_t qstat [mfq_pkg::LEVELS];

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q[0] <= mfq_pkg::QUANTUM_REALTIME_RST;
			quantum_q[1] <= mfq_pkg::QUANTUM_HIGH_RST;
			quantum_q[2] <= mfq_pkg::QUANTUM_MEDIUM_RST;
			quantum_q[3] <= mfq_pkg::QUANTUM_LOW_RST;
		end else if (cfg_we) begin
			quantum_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.opcode       <= s_tuser;
			item_s1.task_id      <= s_tdata[15:0];
			item_s1.realtime_req <= s_tdata[16];
			item_s1.finished     <= s_tdata[17];
		end
		if (fire) begin
			result_q <= result_next;
		end
	end

	mfq_ctrl u_ctrl (
		.fire    (fire),
		.item    (item_s1),
		.qstat   (qstat),
		.quantum (quantum_q),
		.qctl    (qctl),
		.result  (result_next)
	);

	for (genvar g = 0; g < mfq_pkg::LEVELS; g++) begin : g_queue
		mfq_queue #(
			.QUEUE_DEPTH (QUEUE_DEPTH)
		) u_queue (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (qctl[g]),
			.stat   (qstat[g])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q.dropped, result_q.slice, result_q.chosen_level,
		result_q.chosen_id, result_q.ok};

endmodule

`default_nettype wire
